// ----- rtl/chunked_free_list_allocator_assert.svh -----
// Assertion macros for the pool allocator. Clock clk_i, reset rst_ni (active low).
`ifndef CHUNKED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define CHUNKED_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define CFLA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfla: same-cycle check failed");

// Next-cycle implication.
`define CFLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfla: next-cycle check failed");

`endif

// ----- rtl/cfla_pkg.sv -----
package cfla_pkg;

  localparam int CHUNK_SLOTS = 16;
  localparam int MAX_CHUNKS  = 16;
  localparam int LINK_DEPTH  = 256;
  localparam int MAX_FIT     = LINK_DEPTH / CHUNK_SLOTS;

  localparam int SLOT_W  = 8;
  localparam int LINK_W  = SLOT_W + 1;
  localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
  localparam int GROW_W  = $clog2(CHUNK_SLOTS + 1);
  localparam int LIMIT_W = 5;

  localparam logic [LINK_W-1:0]  EMPTY_MARK  = LINK_W'(LINK_DEPTH);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_NULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_GROW
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [SLOT_W-1:0] slot;
    logic              is_null;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_res;
    status_e           status;
  } res_t;

endpackage

// ----- rtl/chunked_free_list_allocator.sv -----
//   port group          dir  handshake               payload
//   -----------------   ---  ----------------------  ---------------------------
//   command             in   start_i && !busy_o      cmd_i   (command/slot/is_null)
//   result              out  res_valid_o, 1 cycle    res_o   (slot_res/status)
//   chunk_limit config  in   cfg_we_i                cfg_wdata_i
//
// Per item: free, null free and out of memory are handled in the idle state; an
// allocate from a non-empty list adds one link memory read; an allocate that links a
// fresh chunk writes one link per slot (single write port).
// The result strobe follows the item's last busy cycle; the next item fits there.
// Reset clears head, chunk count and control; the link memory holds no reset.
// The result receiver cannot stall; each result is shown for one cycle only.

// Pool allocator: LIFO free list of slot indices held in a link memory.
module chunked_free_list_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  cfla_pkg::cmd_t                      cmd_i,
  output logic                                busy_o,
  output logic                                res_valid_o,
  output cfla_pkg::res_t                      res_o,
  input  logic                                cfg_we_i,
  input  logic [cfla_pkg::LIMIT_W-1:0]        cfg_wdata_i
);

  // link memory, one read and one write port, registered read
  logic [cfla_pkg::LINK_W-1:0] link_mem [cfla_pkg::LINK_DEPTH];
  logic                        mem_we;
  logic [cfla_pkg::SLOT_W-1:0] mem_waddr;
  logic [cfla_pkg::LINK_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [cfla_pkg::LINK_W-1:0] mem_rdata_q;

  cfla_pkg::state_e              state_q, state_d;
  logic [cfla_pkg::LINK_W-1:0]   head_q, head_d;
  logic [cfla_pkg::CNT_W-1:0]    chunks_q, chunks_d;
  logic [cfla_pkg::LIMIT_W-1:0]  limit_q;
  logic [cfla_pkg::SLOT_W-1:0]   base_q, base_d;
  logic [cfla_pkg::GROW_W-1:0]   cnt_q, cnt_d;
  logic                          res_valid_q, res_valid_d;
  cfla_pkg::res_t                res_q, res_d;

  logic                          accept;
  logic                          grow_ok;
  logic                          head_empty;
  logic [cfla_pkg::SLOT_W-1:0]   grow_slot;

  assign accept     = start_i && !busy_o;
  assign head_empty = head_q[cfla_pkg::SLOT_W];
  assign grow_slot  = base_q + cfla_pkg::SLOT_W'(cnt_q);

  // growth allowed below the configured limit, MAX_CHUNKS and the slot space
  assign grow_ok = (32'(chunks_q) < 32'(limit_q)) &&
                   (32'(chunks_q) < cfla_pkg::MAX_CHUNKS) &&
                   (32'(chunks_q) < cfla_pkg::MAX_FIT);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= link_mem[head_q[cfla_pkg::SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfla_pkg::S_IDLE;
      head_q      <= cfla_pkg::EMPTY_MARK;
      chunks_q    <= '0;
      limit_q     <= cfla_pkg::LIMIT_RESET;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      chunks_q    <= chunks_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    chunks_d    = chunks_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = cmd_i.slot;
    mem_wdata   = head_q;
    mem_re      = 1'b0;
    busy_o      = 1'b1;

    case (state_q)
      cfla_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (accept) begin
          if (cmd_i.command == cfla_pkg::CMD_FREE) begin
            res_valid_d    = 1'b1;
            res_d.slot_res = '0;
            if (cmd_i.is_null) begin
              res_d.status = cfla_pkg::ST_NULL;
            end else begin
              // push: link the slot to the old head
              mem_we       = 1'b1;
              head_d       = {1'b0, cmd_i.slot};
              res_d.status = cfla_pkg::ST_OK;
            end
          end else if (!head_empty) begin
            mem_re  = 1'b1;
            state_d = cfla_pkg::S_POP;
          end else if (grow_ok) begin
            base_d  = cfla_pkg::SLOT_W'(32'(chunks_q) * cfla_pkg::CHUNK_SLOTS);
            cnt_d   = '0;
            state_d = cfla_pkg::S_GROW;
          end else begin
            res_valid_d    = 1'b1;
            res_d.slot_res = '0;
            res_d.status   = cfla_pkg::ST_OOM;
          end
        end
      end

      cfla_pkg::S_POP: begin
        // link read of the old head is back
        head_d         = mem_rdata_q;
        res_valid_d    = 1'b1;
        res_d.slot_res = head_q[cfla_pkg::SLOT_W-1:0];
        res_d.status   = cfla_pkg::ST_OK;
        state_d        = cfla_pkg::S_IDLE;
      end

      cfla_pkg::S_GROW: begin
        // one link per cycle, ascending: slot i points at slot i-1, first at old head
        mem_we    = 1'b1;
        mem_waddr = grow_slot;
        mem_wdata = (cnt_q == '0) ? head_q : {1'b0, grow_slot - cfla_pkg::SLOT_W'(1)};
        cnt_d     = cnt_q + cfla_pkg::GROW_W'(1);
        if (32'(cnt_q) == cfla_pkg::CHUNK_SLOTS - 1) begin
          // highest slot goes straight out, no read needed
          chunks_d       = chunks_q + cfla_pkg::CNT_W'(1);
          head_d         = (cfla_pkg::CHUNK_SLOTS == 1) ? head_q :
                           {1'b0, grow_slot - cfla_pkg::SLOT_W'(1)};
          res_valid_d    = 1'b1;
          res_d.slot_res = grow_slot;
          res_d.status   = cfla_pkg::ST_OK;
          state_d        = cfla_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = cfla_pkg::S_IDLE;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `include "chunked_free_list_allocator_assert.svh"

  // out of memory leaves an empty list behind
  `CFLA_ASSERT_NOW(a_oom_empty, res_valid_q && (res_q.status == cfla_pkg::ST_OOM), head_empty)
  // a chunk is only linked while the list is empty
  `CFLA_ASSERT_NOW(a_grow_empty, state_q == cfla_pkg::S_GROW, head_q == cfla_pkg::EMPTY_MARK)
  // chunk count never passes its ceiling
  `CFLA_ASSERT_NOW(a_chunk_cap, 1'b1, 32'(chunks_q) <= cfla_pkg::MAX_CHUNKS)
  // a pop always finishes in the following cycle with a result
  `CFLA_ASSERT_NEXT(a_pop_done, state_q == cfla_pkg::S_POP, res_valid_q)

endmodule
